FILE: rtl/sfmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmc_pkg
// shared widths, request codes and status codes of the sequenced fifo
// ----------------------------------------------------------------------------
package sfmc_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int FUNC_W = 3;
	localparam int ST_W   = 2;
	localparam int PC_W   = 64;
	localparam int UPC_W  = 16;
	localparam int IDX_W  = 64;

	localparam logic [FUNC_W-1:0] FN_PUSH    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MATCH   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd4;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

endpackage

FILE: rtl/sequenced_fifo_match_consume.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_fifo_match_consume
// ring fifo of pc / micro-pc pairs addressed by a growing sequence index
// ----------------------------------------------------------------------------
// Each request is accepted and the entry memory is read at the accepting edge
// into the stage-one registers; in the second stage the memory data is
// checked, the queue state is updated and the response is loaded into the
// output register. in_stall stays high while a request sits in that second
// stage, and the second stage waits while an earlier response in the output
// register is still stalled. Entries live in one synchronous memory of DEPTH
// slots with one write and one read port; the oldest index, the entry count,
// the consume offset and the head slot are kept in flip-flops, so no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module sequenced_fifo_match_consume #(
	parameter int DEPTH = sfmc_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sfmc_pkg::FUNC_W-1:0]  func,
	input  logic [sfmc_pkg::PC_W-1:0]    pc_value,
	input  logic [sfmc_pkg::UPC_W-1:0]   micro_pc,
	input  logic [sfmc_pkg::IDX_W-1:0]   seq_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sfmc_pkg::ST_W-1:0]    status,
	output logic [sfmc_pkg::IDX_W-1:0]   out_index,
	output logic [sfmc_pkg::PC_W-1:0]    out_pc,
	output logic [sfmc_pkg::UPC_W-1:0]   out_micro_pc
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = sfmc_pkg::PC_W + sfmc_pkg::UPC_W;
	localparam int IDX_W = sfmc_pkg::IDX_W;

	function automatic logic [AW-1:0] wrap_slot(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// queue state
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] coff_q;
	logic [AW-1:0]    head_q;

	// entry memory
	logic [ENT_W-1:0] entry_mem_q [DEPTH];
	logic [ENT_W-1:0] rd_data_s1;

	// stage one
	logic                        valid_s1;
	logic [sfmc_pkg::FUNC_W-1:0] func_s1;
	logic [sfmc_pkg::PC_W-1:0]   pc_s1;
	logic [sfmc_pkg::UPC_W-1:0]  upc_s1;
	logic [IDX_W-1:0]            seq_s1;
	logic                        seq_live_s1;
	logic [CNT_W-1:0]            rel_n_s1;

	// output register
	logic                        out_valid_q;
	logic [sfmc_pkg::ST_W-1:0]   status_q;
	logic [IDX_W-1:0]            out_index_q;
	logic [sfmc_pkg::PC_W-1:0]   out_pc_q;
	logic [sfmc_pkg::UPC_W-1:0]  out_upc_q;

	logic             acc;
	logic             s1_done;
	logic [IDX_W:0]   diff;
	logic [IDX_W-1:0] seq_off;
	logic             seq_live;
	logic             seq_ge;
	logic [CNT_W-1:0] rel_n;
	logic [CNT_W-1:0] rd_off;
	logic [AW-1:0]    rd_addr;

	logic                        full;
	logic                        con_live;
	logic [sfmc_pkg::PC_W-1:0]   rd_pc;
	logic [sfmc_pkg::UPC_W-1:0]  rd_upc;
	logic [CNT_W-1:0]            add_off;
	logic [IDX_W-1:0]            sum_index;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;

	logic [sfmc_pkg::ST_W-1:0]   st_nxt;
	logic [IDX_W-1:0]            idx_nxt;
	logic [sfmc_pkg::PC_W-1:0]   pc_nxt;
	logic [sfmc_pkg::UPC_W-1:0]  upc_nxt;
	logic [IDX_W-1:0]            oldest_nxt;
	logic [CNT_W-1:0]            count_nxt;
	logic [CNT_W-1:0]            coff_nxt;
	logic [AW-1:0]               head_nxt;

	// accept side
	assign in_stall = valid_s1;
	assign acc      = in_valid && !valid_s1;
	assign s1_done  = valid_s1 && (!out_valid_q || !out_stall);

	assign diff     = {1'b0, seq_index} - {1'b0, oldest_q};
	assign seq_off  = diff[IDX_W-1:0];
	assign seq_live = seq_off < IDX_W'(count_q);
	assign seq_ge   = !diff[IDX_W];

	always_comb begin
		rel_n = '0;
		if (count_q != '0 && seq_ge) begin
			rel_n = seq_live ? (seq_off[CNT_W-1:0] + CNT_W'(1)) : count_q;
		end
	end

	assign rd_off  = (func == sfmc_pkg::FN_READ) ? seq_off[CNT_W-1:0] : coff_q;
	assign rd_addr = wrap_slot(CNT_W'(head_q), rd_off);

	// second stage
	assign full     = count_q == CNT_W'(DEPTH);
	assign con_live = coff_q < count_q;
	assign rd_pc    = rd_data_s1[ENT_W-1:sfmc_pkg::UPC_W];
	assign rd_upc   = rd_data_s1[sfmc_pkg::UPC_W-1:0];

	always_comb begin
		case (func_s1)
			sfmc_pkg::FN_PUSH:    add_off = count_q;
			sfmc_pkg::FN_RELEASE: add_off = rel_n_s1;
			default:              add_off = coff_q;
		endcase
	end

	assign sum_index = oldest_q + IDX_W'(add_off);
	assign wr_en     = s1_done && func_s1 == sfmc_pkg::FN_PUSH && !full;
	assign wr_addr   = wrap_slot(CNT_W'(head_q), count_q);

	always_comb begin
		st_nxt     = sfmc_pkg::ST_ABSENT;
		idx_nxt    = '0;
		pc_nxt     = '0;
		upc_nxt    = '0;
		oldest_nxt = oldest_q;
		count_nxt  = count_q;
		coff_nxt   = coff_q;
		head_nxt   = head_q;
		case (func_s1)
			sfmc_pkg::FN_PUSH: begin
				if (full) begin
					st_nxt = sfmc_pkg::ST_FULL;
				end else begin
					st_nxt    = sfmc_pkg::ST_OK;
					idx_nxt   = sum_index;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			sfmc_pkg::FN_PEEK: begin
				if (con_live) begin
					st_nxt  = sfmc_pkg::ST_OK;
					idx_nxt = sum_index;
					pc_nxt  = rd_pc;
					upc_nxt = rd_upc;
				end
			end
			sfmc_pkg::FN_MATCH: begin
				if (con_live && rd_pc == pc_s1 && rd_upc == upc_s1) begin
					st_nxt   = sfmc_pkg::ST_OK;
					idx_nxt  = sum_index;
					pc_nxt   = rd_pc;
					upc_nxt  = rd_upc;
					coff_nxt = coff_q + CNT_W'(1);
				end
			end
			sfmc_pkg::FN_READ: begin
				if (seq_live_s1) begin
					st_nxt  = sfmc_pkg::ST_OK;
					idx_nxt = seq_s1;
					pc_nxt  = rd_pc;
					upc_nxt = rd_upc;
				end
			end
			sfmc_pkg::FN_RELEASE: begin
				st_nxt     = sfmc_pkg::ST_OK;
				idx_nxt    = sum_index;
				oldest_nxt = sum_index;
				count_nxt  = count_q - rel_n_s1;
				head_nxt   = wrap_slot(CNT_W'(head_q), rel_n_s1);
				coff_nxt   = (coff_q > rel_n_s1) ? (coff_q - rel_n_s1) : '0;
			end
			default: begin
				st_nxt = sfmc_pkg::ST_ABSENT;
			end
		endcase
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= {pc_s1, upc_s1};
		end
		if (acc) begin
			rd_data_s1 <= entry_mem_q[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			oldest_q    <= '0;
			count_q     <= '0;
			coff_q      <= '0;
			head_q      <= '0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				out_valid_q <= 1'b1;
				oldest_q    <= oldest_nxt;
				count_q     <= count_nxt;
				coff_q      <= coff_nxt;
				head_q      <= head_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1     <= func;
			pc_s1       <= pc_value;
			upc_s1      <= micro_pc;
			seq_s1      <= seq_index;
			seq_live_s1 <= seq_live;
			rel_n_s1    <= rel_n;
		end
		if (s1_done) begin
			status_q    <= st_nxt;
			out_index_q <= idx_nxt;
			out_pc_q    <= pc_nxt;
			out_upc_q   <= upc_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_index    = out_index_q;
	assign out_pc       = out_pc_q;
	assign out_micro_pc = out_upc_q;

	// checks
	a_coff_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		coff_q <= count_q)
		else $error("consume offset beyond entry count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done && func_s1 == sfmc_pkg::FN_PUSH && full |=> $stable(count_q))
		else $error("refused push changed entry count");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done && func_s1 == sfmc_pkg::FN_RELEASE
		|=> out_valid_q && status_q == sfmc_pkg::ST_OK)
		else $error("release response missing or not ok");

endmodule
